// ----- design/spi_master_byte_shifter_unit_defines.svh -----
// Assertion helpers used by the file that checks this block.
`ifndef SPI_MASTER_BYTE_SHIFTER_UNIT_DEFINES_SVH
`define SPI_MASTER_BYTE_SHIFTER_UNIT_DEFINES_SVH

// The property must hold at every rising clock edge outside reset.
`define SPIMBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define SPIMBS_NEVER(label, cond, msg) \
  `SPIMBS_ASSERT(label, !(cond), msg)

`endif

// ----- design/spimbs_pkg.sv -----
package spimbs_pkg;

  localparam int unsigned WORD_BITS = 8;
  localparam int unsigned BITS_W    = $clog2(WORD_BITS + 1);
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Commands carried by an input item.
  localparam logic [1:0] CMD_IDLE  = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_XFER  = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  // Engine states.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_BEGIN = 2'd1;
  localparam logic [1:0] MODE_XFER  = 2'd2;
  localparam logic [1:0] MODE_END   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CPOL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPHA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD = 3'd4;

  typedef struct packed {
    logic              cpol;
    logic              cpha;
    logic              lsb_first;
    logic [TICK_W-1:0] half_ticks;
    logic [TICK_W-1:0] guard_ticks;
  } spimbs_cfg_t;

  // A write to the polarity register, which also moves an idle SCLK.
  typedef struct packed {
    logic en;
    logic value;
  } spimbs_polwr_t;

  typedef struct packed {
    logic                 sclk;
    logic                 mosi;
    logic                 sel_n;
    logic                 busy;
    logic                 rx_valid;
    logic [WORD_BITS-1:0] rx_byte;
  } spimbs_res_t;

  function automatic logic out_bit(input logic [WORD_BITS-1:0] word, input logic lsb);
    return lsb ? word[0] : word[WORD_BITS-1];
  endfunction

  function automatic logic [WORD_BITS-1:0] shift_word(input logic [WORD_BITS-1:0] word,
                                                      input logic lsb);
    return lsb ? {1'b0, word[WORD_BITS-1:1]} : {word[WORD_BITS-2:0], 1'b0};
  endfunction

  function automatic logic [WORD_BITS-1:0] sample_word(input logic [WORD_BITS-1:0] word,
                                                       input logic lsb, input logic bit_in);
    return lsb ? {bit_in, word[WORD_BITS-1:1]} : {word[WORD_BITS-2:0], bit_in};
  endfunction

endpackage

// ----- design/spimbs_cfg.sv -----
module spimbs_cfg
  import spimbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_data_i,
  output spimbs_cfg_t          cfg_o,
  output spimbs_polwr_t        polwr_o
);

  spimbs_cfg_t cfg_q, cfg_d;
  logic        wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (cfg_index_i)
        CFG_CPOL:  cfg_d.cpol        = cfg_data_i[0];
        CFG_CPHA:  cfg_d.cpha        = cfg_data_i[0];
        CFG_LSB:   cfg_d.lsb_first   = cfg_data_i[0];
        CFG_HALF:  cfg_d.half_ticks  = cfg_data_i;
        CFG_GUARD: cfg_d.guard_ticks = cfg_data_i;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpol        <= 1'b0;
      cfg_q.cpha        <= 1'b0;
      cfg_q.lsb_first   <= 1'b0;
      cfg_q.half_ticks  <= TICK_W'(1);
      cfg_q.guard_ticks <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o         = cfg_q;
  assign polwr_o.en    = wr && (cfg_index_i == CFG_CPOL);
  assign polwr_o.value = cfg_data_i[0];

endmodule

// ----- design/spimbs_core.sv -----
module spimbs_core
  import spimbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [1:0]           command_i,
  input  logic [WORD_BITS-1:0] tx_byte_i,
  input  logic                 miso_level_i,
  input  spimbs_cfg_t          cfg_i,
  input  spimbs_polwr_t        polwr_i,
  output spimbs_res_t          res_o
);

  logic [WORD_BITS-1:0] tx_q, tx_d, rx_q, rx_d, tx_next;
  logic [BITS_W-1:0]    bits_q, bits_d;
  logic                 second_q, second_d;
  logic [TICK_W-1:0]    tick_q, tick_d, tick_dec, half_len;
  logic [1:0]           mode_q, mode_d;
  logic                 sclk_q, sclk_d, mosi_q, mosi_d, sel_q, sel_d;
  logic                 rx_done;

  // A zero half period counts as one tick.
  assign half_len = (cfg_i.half_ticks == '0) ? TICK_W'(1) : cfg_i.half_ticks;
  assign tick_dec = tick_q - TICK_W'(1);
  assign tx_next  = shift_word(tx_q, cfg_i.lsb_first);

  always_comb begin
    tx_d     = tx_q;
    rx_d     = rx_q;
    bits_d   = bits_q;
    second_d = second_q;
    tick_d   = tick_q;
    mode_d   = mode_q;
    sclk_d   = sclk_q;
    mosi_d   = mosi_q;
    sel_d    = sel_q;
    rx_done  = 1'b0;
    if (step_i) begin
      case (mode_q)
        MODE_IDLE: begin
          case (command_i)
            CMD_BEGIN: begin
              sel_d = 1'b0;
              if (cfg_i.guard_ticks != '0) begin
                tick_d = cfg_i.guard_ticks;
                mode_d = MODE_BEGIN;
              end
            end
            CMD_END: begin
              if (cfg_i.guard_ticks != '0) begin
                tick_d = cfg_i.guard_ticks;
                mode_d = MODE_END;
              end else begin
                sel_d = 1'b1;
              end
            end
            CMD_XFER: begin
              tx_d     = tx_byte_i;
              rx_d     = '0;
              bits_d   = BITS_W'(WORD_BITS);
              second_d = 1'b0;
              tick_d   = half_len;
              sclk_d   = cfg_i.cpol;
              mode_d   = MODE_XFER;
              if (!cfg_i.cpha) begin
                mosi_d = out_bit(tx_byte_i, cfg_i.lsb_first);
              end
            end
            default: ;
          endcase
        end
        MODE_BEGIN, MODE_END: begin
          tick_d = tick_dec;
          if (tick_dec == '0) begin
            if (mode_q == MODE_END) begin
              sel_d = 1'b1;
            end
            mode_d = MODE_IDLE;
          end
        end
        MODE_XFER: begin
          tick_d = tick_dec;
          if (tick_dec == '0) begin
            if (!second_q) begin
              if (cfg_i.cpha) begin
                mosi_d = out_bit(tx_q, cfg_i.lsb_first);
              end else begin
                rx_d = sample_word(rx_q, cfg_i.lsb_first, miso_level_i);
              end
              sclk_d   = ~cfg_i.cpol;
              second_d = 1'b1;
              tick_d   = half_len;
            end else begin
              if (cfg_i.cpha) begin
                rx_d = sample_word(rx_q, cfg_i.lsb_first, miso_level_i);
              end
              sclk_d   = cfg_i.cpol;
              tx_d     = tx_next;
              bits_d   = bits_q - BITS_W'(1);
              second_d = 1'b0;
              if (bits_q == BITS_W'(1)) begin
                rx_done = 1'b1;
                mode_d  = MODE_IDLE;
              end else begin
                if (!cfg_i.cpha) begin
                  mosi_d = out_bit(tx_next, cfg_i.lsb_first);
                end
                tick_d = half_len;
              end
            end
          end
        end
        default: ;
      endcase
    end
    // Outside a transfer a new polarity moves SCLK to its idle level at once.
    if (polwr_i.en && (mode_q != MODE_XFER)) begin
      sclk_d = polwr_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q     <= '0;
      rx_q     <= '0;
      bits_q   <= '0;
      second_q <= 1'b0;
      tick_q   <= '0;
      mode_q   <= MODE_IDLE;
      sclk_q   <= 1'b0;
      mosi_q   <= 1'b1;
      sel_q    <= 1'b1;
    end else begin
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      bits_q   <= bits_d;
      second_q <= second_d;
      tick_q   <= tick_d;
      mode_q   <= mode_d;
      sclk_q   <= sclk_d;
      mosi_q   <= mosi_d;
      sel_q    <= sel_d;
    end
  end

  assign res_o.sclk     = sclk_d;
  assign res_o.mosi     = mosi_d;
  assign res_o.sel_n    = sel_d;
  assign res_o.busy     = (mode_d != MODE_IDLE);
  assign res_o.rx_valid = rx_done;
  assign res_o.rx_byte  = rx_done ? rx_d : '0;

endmodule

// ----- design/spi_master_byte_shifter_unit.sv -----
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  command_i, tx_byte_i, miso_level_i
// out       output     out_valid_o/out_stall_i sclk_level_o, mosi_level_o, select_n_o,
//                                             busy_res_o, rx_valid_o, rx_byte_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item is one tick of the serial engine and gives exactly one result item.
// An item is held in the input register until the output register can take its result,
// which is then registered there; one item is taken every cycle while the output is
// free or being drained.
// A stalled output holds its result and the input register backs up behind it.
// Reset (rst_ni low, asynchronous) idles the core: SCLK low, MOSI high, chip select high.
`include "spi_master_byte_shifter_unit_defines.svh"

module spi_master_byte_shifter_unit
  import spimbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [WORD_BITS-1:0] tx_byte_i,
  input  logic                 miso_level_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 sclk_level_o,
  output logic                 mosi_level_o,
  output logic                 select_n_o,
  output logic                 busy_res_o,
  output logic                 rx_valid_o,
  output logic [WORD_BITS-1:0] rx_byte_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_data_i
);

  spimbs_cfg_t   cfg;
  spimbs_polwr_t polwr;
  spimbs_res_t   res;

  logic                 in_valid_q, in_valid_d;
  logic [1:0]           cmd_q;
  logic [WORD_BITS-1:0] txb_q;
  logic                 miso_q;
  logic                 out_valid_q, out_valid_d;
  spimbs_res_t          res_q;
  logic                 fire, in_accept;

  // The held item moves into the engine whenever the output register can take its result.
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_valid_q && out_stall_i);

  spimbs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .polwr_o     (polwr)
  );

  spimbs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (fire),
    .command_i    (cmd_q),
    .tx_byte_i    (txb_q),
    .miso_level_i (miso_q),
    .cfg_i        (cfg),
    .polwr_i      (polwr),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= command_i;
      txb_q  <= tx_byte_i;
      miso_q <= miso_level_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sclk_level_o = res_q.sclk;
  assign mosi_level_o = res_q.mosi;
  assign select_n_o   = res_q.sel_n;
  assign busy_res_o   = res_q.busy;
  assign rx_valid_o   = res_q.rx_valid;
  assign rx_byte_o    = res_q.rx_byte;

  `SPIMBS_NEVER(a_stall_needs_full_out, in_stall_o && !out_valid_o, "input stalled with output empty")
  `SPIMBS_ASSERT(a_done_not_busy, (out_valid_o && rx_valid_o) |-> !busy_res_o, "busy after last bit")
  `SPIMBS_ASSERT(a_rx_zero_idle, (out_valid_o && !rx_valid_o) |-> (rx_byte_o == '0), "stray rx byte")

endmodule

// ----- test/spi_master_byte_shifter_unit_tb.sv -----
`timescale 1ns / 100ps

module spi_master_byte_shifter_unit_tb;
  import spimbs_pkg::*;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [1:0]           cmd;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [7:0]           data;
    logic                 miso;
    logic [15:0]          idle_after;
    logic                 typed;
    spimbs_res_t          want;
  } stim_row_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [TICK_W-1:0]    data;
  } reg_wr_t;

  localparam spimbs_res_t LINES_AT_RESET = '{sclk: 1'b0, mosi: 1'b1, sel_n: 1'b1,
                                             busy: 1'b0, rx_valid: 1'b0, rx_byte: '0};
  localparam spimbs_res_t LINES_SELECTED = '{sclk: 1'b0, mosi: 1'b1, sel_n: 1'b0,
                                             busy: 1'b0, rx_valid: 1'b0, rx_byte: '0};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           command_i = CMD_IDLE;
  logic [WORD_BITS-1:0] tx_byte_i = '0;
  logic                 miso_level_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 sclk_level_o;
  logic                 mosi_level_o;
  logic                 select_n_o;
  logic                 busy_res_o;
  logic                 rx_valid_o;
  logic [WORD_BITS-1:0] rx_byte_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [TICK_W-1:0]    cfg_data_i = '0;

  // Shadow copy of the serial engine, stepped once per accepted item.
  spimbs_cfg_t          pred_cfg = '{cpol: 1'b0, cpha: 1'b0, lsb_first: 1'b0,
                                     half_ticks: 8'd1, guard_ticks: 8'd0};
  logic [WORD_BITS-1:0] tx_sr = '0;
  logic [WORD_BITS-1:0] rx_sr = '0;
  logic [BITS_W-1:0]    bits_left = '0;
  logic                 second_half = 1'b0;
  logic [TICK_W-1:0]    tick_cnt = '0;
  logic [1:0]           eng_mode = MODE_IDLE;
  logic                 sclk_q = 1'b0;
  logic                 mosi_q = 1'b1;
  logic                 sel_q = 1'b1;

  spimbs_res_t levels_due[$];
  reg_wr_t     reg_burst[$];
  stim_row_t   dir_rows[$];

  int unsigned mismatch_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned calm_left = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  spimbs_res_t due_lv;
  spimbs_res_t seen_lv;

  spi_master_byte_shifter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .tx_byte_i    (tx_byte_i),
    .miso_level_i (miso_level_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sclk_level_o (sclk_level_o),
    .mosi_level_o (mosi_level_o),
    .select_n_o   (select_n_o),
    .busy_res_o   (busy_res_o),
    .rx_valid_o   (rx_valid_o),
    .rx_byte_o    (rx_byte_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [TICK_W-1:0] half_len();
    return (pred_cfg.half_ticks == '0) ? TICK_W'(1) : pred_cfg.half_ticks;
  endfunction

  function automatic logic lead_bit();
    return pred_cfg.lsb_first ? tx_sr[0] : tx_sr[WORD_BITS-1];
  endfunction

  function automatic void take_miso(input logic miso);
    if (pred_cfg.lsb_first) begin
      rx_sr = {miso, rx_sr[WORD_BITS-1:1]};
    end else begin
      rx_sr = {rx_sr[WORD_BITS-2:0], miso};
    end
  endfunction

  function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TICK_W-1:0] data);
    case (idx)
      CFG_CPOL: begin
        pred_cfg.cpol = data[0];
        if (eng_mode != MODE_XFER) sclk_q = data[0];
      end
      CFG_CPHA:  pred_cfg.cpha = data[0];
      CFG_LSB:   pred_cfg.lsb_first = data[0];
      CFG_HALF:  pred_cfg.half_ticks = data;
      CFG_GUARD: pred_cfg.guard_ticks = data;
      default: ;
    endcase
  endfunction

  // Steps the shadow engine by one tick and returns the line levels after it.
  function automatic spimbs_res_t advance_engine(input logic [1:0] cmd,
                                                 input logic [WORD_BITS-1:0] txb,
                                                 input logic miso);
    spimbs_res_t lv;
    logic        done;
    done = 1'b0;
    lv = '0;
    case (eng_mode)
      MODE_IDLE: begin
        if (cmd == CMD_BEGIN) begin
          sel_q = 1'b0;
          if (pred_cfg.guard_ticks != '0) begin
            tick_cnt = pred_cfg.guard_ticks;
            eng_mode = MODE_BEGIN;
          end
        end else if (cmd == CMD_END) begin
          if (pred_cfg.guard_ticks != '0) begin
            tick_cnt = pred_cfg.guard_ticks;
            eng_mode = MODE_END;
          end else begin
            sel_q = 1'b1;
          end
        end else if (cmd == CMD_XFER) begin
          tx_sr = txb;
          rx_sr = '0;
          bits_left = BITS_W'(WORD_BITS);
          second_half = 1'b0;
          tick_cnt = half_len();
          sclk_q = pred_cfg.cpol;
          eng_mode = MODE_XFER;
          if (!pred_cfg.cpha) mosi_q = lead_bit();
        end
      end
      MODE_BEGIN, MODE_END: begin
        tick_cnt = tick_cnt - 1'b1;
        if (tick_cnt == '0) begin
          if (eng_mode == MODE_END) sel_q = 1'b1;
          eng_mode = MODE_IDLE;
        end
      end
      default: begin
        tick_cnt = tick_cnt - 1'b1;
        if (tick_cnt == '0) begin
          if (!second_half) begin
            if (pred_cfg.cpha) begin
              mosi_q = lead_bit();
            end else begin
              take_miso(miso);
            end
            sclk_q = ~pred_cfg.cpol;
            second_half = 1'b1;
            tick_cnt = half_len();
          end else begin
            if (pred_cfg.cpha) take_miso(miso);
            sclk_q = pred_cfg.cpol;
            tx_sr = pred_cfg.lsb_first ? (tx_sr >> 1) : (tx_sr << 1);
            bits_left = bits_left - 1'b1;
            second_half = 1'b0;
            if (bits_left == '0) begin
              done = 1'b1;
              eng_mode = MODE_IDLE;
            end else begin
              if (!pred_cfg.cpha) mosi_q = lead_bit();
              tick_cnt = half_len();
            end
          end
        end
      end
    endcase
    lv.sclk = sclk_q;
    lv.mosi = mosi_q;
    lv.sel_n = sel_q;
    lv.busy = (eng_mode != MODE_IDLE);
    lv.rx_valid = done;
    lv.rx_byte = done ? rx_sr : '0;
    return lv;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic stim_row_t tick_row(input logic [1:0] cmd, input logic [7:0] data,
                                         input logic miso, input int idle_after);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.cmd = cmd;
    r.data = data;
    r.miso = miso;
    r.idle_after = 16'(idle_after);
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [7:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.cmd = CMD_IDLE;
    r.reg_idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic void queue_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [TICK_W-1:0] data);
    reg_wr_t w;
    w.idx = idx;
    w.data = data;
    reg_burst.push_back(w);
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_tick(input logic [1:0] cmd, input logic [WORD_BITS-1:0] txb,
                           input logic miso, input logic typed, input spimbs_res_t want);
    int          gap;
    spimbs_res_t lv;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    tx_byte_i <= txb;
    miso_level_i <= miso;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lv = advance_engine(cmd, txb, miso);
    levels_due.push_back(typed ? want : lv);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Register writes only go in once every item in flight has come out.
  task automatic write_regs();
    in_valid_i <= 1'b0;
    while (levels_due.size() != 0) @(negedge clk_i);
    foreach (reg_burst[k]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_burst[k].idx;
      cfg_data_i <= reg_burst[k].data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      set_reg(reg_burst[k].idx, reg_burst[k].data);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    reg_burst.delete();
  endtask

  // Idle ticks until the engine is free, with the odd command thrown in while busy.
  task automatic tick_until_idle(input logic fixed, input logic lvl);
    logic [1:0] cmd;
    while (eng_mode != MODE_IDLE) begin
      cmd = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(1, 3)) : CMD_IDLE;
      send_tick(cmd, 8'($urandom), fixed ? lvl : 1'($urandom), 1'b0, '0);
    end
  endtask

  task automatic run_sequence();
    int         n;
    int         r;
    logic [7:0] txb;
    logic       fixed;
    logic       lvl;
    logic       framed;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(6, 30);
      repeat (n) send_tick(2'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
      tick_until_idle(1'b0, 1'b0);
    end else begin
      framed = ($urandom_range(0, 9) != 0);
      repeat ($urandom_range(0, 3)) send_tick(CMD_IDLE, 8'($urandom), 1'($urandom), 1'b0, '0);
      if (framed) begin
        send_tick(CMD_BEGIN, 8'($urandom), 1'($urandom), 1'b0, '0);
        tick_until_idle(1'b0, 1'b0);
      end
      n = $urandom_range(1, 4);
      repeat (n) begin
        r = $urandom_range(0, 9);
        txb = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
        fixed = ($urandom_range(0, 3) == 0);
        lvl = 1'($urandom);
        send_tick(CMD_XFER, txb, lvl, 1'b0, '0);
        tick_until_idle(fixed, lvl);
        repeat ($urandom_range(0, 2)) begin
          send_tick(CMD_IDLE, 8'($urandom), 1'($urandom), 1'b0, '0);
        end
      end
      if (framed) begin
        send_tick(CMD_END, 8'($urandom), 1'($urandom), 1'b0, '0);
        tick_until_idle(1'b0, 1'b0);
      end
    end
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    if (mismatch_cnt < 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_lv = '{sclk: sclk_level_o, mosi: mosi_level_o, sel_n: select_n_o,
                  busy: busy_res_o, rx_valid: rx_valid_o, rx_byte: rx_byte_o};
      if (levels_due.size() == 0) begin
        note_mismatch("unexpected item", 0, int'(seen_lv));
      end else begin
        due_lv = levels_due.pop_front();
        if (seen_lv.sclk !== due_lv.sclk) note_mismatch("sclk", due_lv.sclk, seen_lv.sclk);
        if (seen_lv.mosi !== due_lv.mosi) note_mismatch("mosi", due_lv.mosi, seen_lv.mosi);
        if (seen_lv.sel_n !== due_lv.sel_n) note_mismatch("select_n", due_lv.sel_n, seen_lv.sel_n);
        if (seen_lv.busy !== due_lv.busy) note_mismatch("busy", due_lv.busy, seen_lv.busy);
        if (seen_lv.rx_valid !== due_lv.rx_valid) begin
          note_mismatch("rx_valid", due_lv.rx_valid, seen_lv.rx_valid);
        end
        if (seen_lv.rx_byte !== due_lv.rx_byte) begin
          note_mismatch("rx_byte", due_lv.rx_byte, seen_lv.rx_byte);
        end
      end
    end
  end

  // Output back-pressure: short and long stalls, plus one long hold-off that makes
  // the input side fill up while items keep coming.
  initial begin : receiver_stalls
    int   run_left;
    logic stall_now;
    run_left = 0;
    stall_now = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        stall_now = 1'b1;
        run_left = 240;
      end else if (run_left == 0) begin
        stall_now = !stall_now;
        if (stall_now) begin
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end else begin
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 8);
        end
      end
      out_stall_i <= stall_now;
      run_left--;
    end
  end

  initial begin : run_limit
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   r;
    int          pick;

    r = tick_row(CMD_IDLE, 8'h00, 1'b0, 0);
    r.typed = 1'b1;
    r.want = LINES_AT_RESET;
    dir_rows.push_back(r);
    // With no guard the select falls on the command tick itself.
    r = tick_row(CMD_BEGIN, 8'h00, 1'b0, 0);
    r.typed = 1'b1;
    r.want = LINES_SELECTED;
    dir_rows.push_back(r);
    dir_rows.push_back(tick_row(CMD_XFER, 8'hFF, 1'b1, 16));
    dir_rows.push_back(tick_row(CMD_XFER, 8'h00, 1'b0, 16));
    dir_rows.push_back(tick_row(CMD_END, 8'h00, 1'b0, 0));
    dir_rows.push_back(reg_row(CFG_CPOL, 8'h01));
    dir_rows.push_back(reg_row(CFG_CPHA, 8'h01));
    dir_rows.push_back(reg_row(CFG_LSB, 8'h01));
    dir_rows.push_back(reg_row(CFG_HALF, 8'h00));
    dir_rows.push_back(reg_row(CFG_GUARD, 8'h03));
    dir_rows.push_back(tick_row(CMD_BEGIN, 8'h00, 1'b0, 4));
    // Commands that arrive while a transfer runs are dropped.
    dir_rows.push_back(tick_row(CMD_XFER, 8'hA5, 1'b1, 3));
    dir_rows.push_back(tick_row(CMD_END, 8'h00, 1'b0, 0));
    dir_rows.push_back(tick_row(CMD_XFER, 8'h5A, 1'b0, 14));
    dir_rows.push_back(reg_row(CFG_HALF, 8'h04));
    // Register writes in the middle of a byte: new half period at the next edge,
    // and the polarity change must not move SCLK at once while the byte runs.
    dir_rows.push_back(tick_row(CMD_XFER, 8'hC3, 1'b1, 12));
    dir_rows.push_back(reg_row(CFG_HALF, 8'h01));
    dir_rows.push_back(reg_row(CFG_CPOL, 8'h00));
    dir_rows.push_back(reg_row(3'd5, 8'hFF));
    dir_rows.push_back(tick_row(CMD_IDLE, 8'h00, 1'b0, 60));
    dir_rows.push_back(tick_row(CMD_END, 8'h00, 1'b0, 5));
    dir_rows.push_back(reg_row(CFG_CPHA, 8'hFE));
    // Select is high here, so this byte goes out without the slave selected.
    dir_rows.push_back(tick_row(CMD_XFER, 8'h81, 1'b1, 20));
    dir_rows.push_back(reg_row(CFG_GUARD, 8'h28));
    dir_rows.push_back(reg_row(3'd7, 8'h00));
    dir_rows.push_back(tick_row(CMD_BEGIN, 8'h00, 1'b0, 40));
    dir_rows.push_back(tick_row(CMD_END, 8'h00, 1'b1, 40));
    dir_rows.push_back(reg_row(CFG_GUARD, 8'h00));
    dir_rows.push_back(reg_row(CFG_HALF, 8'h03));
    dir_rows.push_back(reg_row(CFG_LSB, 8'h00));
    dir_rows.push_back(tick_row(CMD_XFER, 8'h7E, 1'b0, 16 * 3 + 2));
    dir_rows.push_back(reg_row(CFG_HALF, 8'h01));
    dir_rows.push_back(reg_row(CFG_CPOL, 8'h01));
    dir_rows.push_back(tick_row(CMD_IDLE, 8'h00, 1'b1, 2));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < dir_rows.size(); i++) begin
      r = dir_rows[i];
      if (r.kind == ROW_REG) begin
        queue_reg(r.reg_idx, r.data);
        if (i + 1 == dir_rows.size() || dir_rows[i + 1].kind != ROW_REG) write_regs();
      end else begin
        send_tick(r.cmd, r.data, r.miso, r.typed, r.want);
        repeat (int'(r.idle_after)) send_tick(CMD_IDLE, 8'($urandom), r.miso, 1'b0, '0);
      end
    end

    while (items_sent < 450) begin
      if ($urandom_range(0, 9) < 6) queue_reg(CFG_CPOL, 8'($urandom));
      if ($urandom_range(0, 9) < 6) queue_reg(CFG_CPHA, 8'($urandom));
      if ($urandom_range(0, 9) < 6) queue_reg(CFG_LSB, 8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        queue_reg(CFG_HALF, 8'h00);
      end else if (pick < 85) begin
        queue_reg(CFG_HALF, 8'($urandom_range(1, 3)));
      end else if (pick < 98) begin
        queue_reg(CFG_HALF, 8'($urandom_range(4, 6)));
      end else begin
        queue_reg(CFG_HALF, 8'($urandom_range(7, 8)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_reg(CFG_GUARD, 8'h00);
      end else if (pick < 90) begin
        queue_reg(CFG_GUARD, 8'($urandom_range(1, 4)));
      end else if (pick < 98) begin
        queue_reg(CFG_GUARD, 8'($urandom_range(5, 20)));
      end else begin
        queue_reg(CFG_GUARD, 8'($urandom_range(21, 30)));
      end
      if ($urandom_range(0, 9) == 0) queue_reg(3'($urandom_range(5, 7)), 8'($urandom));
      write_regs();
      hold_armed = 1'b1;
      run_sequence();
    end

    in_valid_i <= 1'b0;
    while (levels_due.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && levels_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
